@@ rtl/core/ierf_pkg.sv @@
// Shared constants for the inverse error function approximation pipeline.
package ierf_pkg;

    localparam int IN_W          = 16;
    localparam int OUT_W         = 15;
    localparam int IN_FRAC_BITS  = 15;
    localparam int OUT_FRAC_BITS = 12;
    localparam int WFRAC         = 28;

    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    localparam logic [30:0] C_T1    = 31'd1162525979;
    localparam logic [30:0] C_INVA  = 31'd1826091537;
    localparam logic [OUT_W-2:0] MAG_MAX = {(OUT_W-1){1'b1}};
    localparam logic [OUT_W-1:0] NEG_SAT = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

@@ rtl/core/ierf_log2.sv @@
// Pipelined fraction of log2 by repeated squaring, one result bit per stage.
module ierf_log2 #(
    parameter int SIDE_W = 7
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [30:0]             i_y,
    input  logic [SIDE_W-1:0]       i_side,
    output logic                    o_valid,
    output logic [ierf_pkg::WFRAC-1:0] o_frac,
    output logic [SIDE_W-1:0]       o_side
);
    import ierf_pkg::*;

    localparam int STEPS = WFRAC;

    logic [STEPS-1:0] r_v;
    logic [30:0]      r_y    [STEPS];
    logic [WFRAC-1:0] r_frac [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic [30:0]       w_yin;
        logic [WFRAC-1:0]  w_fin;
        logic              w_vin;
        logic [SIDE_W-1:0] w_sin;
        logic [61:0]       w_sq;
        logic [31:0]       w_y2;

        if (g == 0) begin : g_first
            assign w_yin = i_y;
            assign w_fin = '0;
            assign w_vin = i_valid;
            assign w_sin = i_side;
        end else begin : g_rest
            assign w_yin = r_y[g-1];
            assign w_fin = r_frac[g-1];
            assign w_vin = r_v[g-1];
            assign w_sin = r_side[g-1];
        end

        assign w_sq = {31'd0, w_yin} * {31'd0, w_yin};
        assign w_y2 = w_sq[61:30];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                // a square of two or more halves the mantissa and yields a one
                r_y[g]    <= w_y2[31] ? w_y2[31:1] : w_y2[30:0];
                r_frac[g] <= {w_fin[WFRAC-2:0], w_y2[31]};
                r_side[g] <= w_sin;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_frac  = r_frac[STEPS-1];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ rtl/core/ierf_isqrt.sv @@
// Pipelined integer square root, one result bit per stage.
module ierf_isqrt #(
    parameter int W      = 64,
    parameter int SIDE_W = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [W-1:0]      i_op,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [W/2-1:0]    o_root,
    output logic [SIDE_W-1:0] o_side
);
    import ierf_pkg::*;

    localparam int STEPS = W / 2;

    logic [STEPS-1:0]  r_v;
    logic [W-1:0]      r_rem  [STEPS];
    logic [W-1:0]      r_res  [STEPS];
    logic [SIDE_W-1:0] r_side [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam logic [W-1:0] BIT = {{(W-1){1'b0}}, 1'b1} << (W - 2 - 2 * g);

        logic [W-1:0]      w_rem;
        logic [W-1:0]      w_res;
        logic              w_vin;
        logic [SIDE_W-1:0] w_sin;
        logic [W-1:0]      w_trial;
        logic              w_ge;

        if (g == 0) begin : g_first
            assign w_rem = i_op;
            assign w_res = '0;
            assign w_vin = i_valid;
            assign w_sin = i_side;
        end else begin : g_rest
            assign w_rem = r_rem[g-1];
            assign w_res = r_res[g-1];
            assign w_vin = r_v[g-1];
            assign w_sin = r_side[g-1];
        end

        assign w_trial = w_res + BIT;
        assign w_ge    = (w_rem >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= w_ge ? (w_rem - w_trial) : w_rem;
                r_res[g]  <= w_ge ? ((w_res >> 1) + BIT) : (w_res >> 1);
                r_side[g] <= w_sin;
            end
        end
    end

    assign o_valid = r_v[STEPS-1];
    assign o_root  = r_res[STEPS-1][W/2-1:0];
    assign o_side  = r_side[STEPS-1];

endmodule

@@ rtl/core/inverse_erf_approx.sv @@
// Top level: pipelined inverse error function approximation (a = 0.147).
//
// Usage:
//   Slave channel i_s_*: one request per beat, tdata holds the argument x as
//   signed Q1.15. Master channel o_m_*: one result per request, in order;
//   tdata holds inv_erf as signed Q3.12, tuser the saturation flag.
//   The datapath is a 102-stage pipeline; a new request may enter every cycle
//   while the output register is not stalled (one item per cycle sustained).
//   The stage count is set by the 28 squaring steps of the log2 unit and the
//   two 32-step square-root units, one bit per stage each.
//   All stages advance together: when the output register holds a result
//   that is not taken, the whole pipeline holds and o_s_tready drops, so no
//   request is lost or repeated; bubbles travel as cleared valid bits.
//   Reset (synchronous, active low) clears every valid bit; payload
//   registers are left as they are.
//   An argument of exactly minus one cannot be evaluated: it drives the most
//   negative code and raises tuser. Large magnitudes clamp without the flag.
module inverse_erf_approx (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] arg_value
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [14:0] inv_erf, [15] zero
    output logic [0:0]  o_m_tuser    // [0] saturated
);
    import ierf_pkg::*;

    logic w_en;

    // Stage 0: sign and magnitude
    logic        r0_v, r0_neg, r0_sat;
    logic [15:0] r0_a;
    // Stage 1: m = 1 - x*x in unsigned Q1.30
    logic        r1_v, r1_neg, r1_sat;
    logic [30:0] r1_m;
    // Stage 2: normalise
    logic        r2_v;
    logic [30:0] r2_y;
    logic [6:0]  r2_side;
    logic [4:0]  n_k;
    logic [30:0] n_y;
    // log2 unit output
    logic             w_lg_v;
    logic [WFRAC-1:0] w_lg_frac;
    logic [6:0]       w_lg_side;
    // Stages 3 to 7
    logic        r3_v, r3_neg, r3_sat;
    logic [31:0] r3_lmag;
    logic        r4_v, r4_neg, r4_sat;
    logic [31:0] r4_wmag;
    logic        r5_v, r5_neg, r5_sat;
    logic signed [32:0] r5_t1;
    logic [34:0] r5_t2;
    logic        r6_v, r6_neg, r6_sat;
    logic signed [32:0] r6_t1;
    logic [34:0] r6_t2;
    logic [61:0] r6_sq;
    logic        r7_v;
    logic [63:0] r7_op;
    logic [34:0] r7_side;
    // Square roots
    logic        w_sa_v;
    logic [31:0] w_sa_root;
    logic [34:0] w_sa_side;
    logic        r8_v;
    logic [63:0] r8_op;
    logic [1:0]  r8_side;
    logic        w_sb_v;
    logic [31:0] w_sb_root;
    logic [1:0]  w_sb_side;
    // Output register
    logic             r_out_v, r_out_sat;
    logic [OUT_W-1:0] r_out_val;

    logic [32:0]  n_lg, n_lmag;
    logic [61:0]  n_wprod;
    logic [62:0]  n_t2prod;
    logic [30:0]  n_t1abs;
    logic [62:0]  n_sqr;
    logic [35:0]  n_d;
    logic signed [33:0] n_diff;
    logic [16:0]  n_mag;
    logic [13:0]  n_mag_sat;
    logic [31:0]  n_m_full;

    localparam logic [32:0] FULL = 33'(2 * IN_FRAC_BITS) << WFRAC;

    // Advance every stage unless a finished result is held back.
    assign w_en       = !r_out_v || i_m_tready;
    assign o_s_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_s_tvalid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= w_lg_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= w_sa_v;
            r_out_v <= w_sb_v;
        end
    end

    // Leading one of m; m stays below 2^31 so k never exceeds 30.
    always_comb begin
        n_k = '0;
        for (int i = 0; i < 31; i++) begin
            if (r1_m[i]) begin
                n_k = 5'(i);
            end
        end
        n_y = r1_m << (5'd30 - n_k);
    end

    assign n_m_full = 32'h4000_0000 - ({16'd0, r0_a} * {16'd0, r0_a});

    always_comb begin
        n_lg   = {w_lg_side[6:2], w_lg_frac};
        n_lmag = (FULL > n_lg) ? (FULL - n_lg) : '0;
    end

    assign n_wprod  = {30'd0, r3_lmag} * {32'd0, LN2_Q30};
    assign n_t2prod = {31'd0, r4_wmag} * {32'd0, C_INVA};
    assign n_t1abs  = r5_t1[32] ? 31'(-r5_t1) : r5_t1[30:0];
    assign n_sqr    = {1'b0, r6_sq} + 63'(64'd1 << (WFRAC - 1));
    assign n_d      = {1'b0, n_sqr[62:WFRAC]} + {1'b0, r6_t2};
    assign n_diff   = $signed({2'b00, w_sa_root}) - $signed({w_sa_side[34], w_sa_side[34:2]});
    assign n_mag    = 17'(({1'b0, w_sb_root} + 33'(33'd1 << (WFRAC - OUT_FRAC_BITS - 1)))
                          >> (WFRAC - OUT_FRAC_BITS));
    assign n_mag_sat = (n_mag > {3'd0, MAG_MAX}) ? MAG_MAX : n_mag[13:0];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 0: split sign and magnitude
            r0_neg <= i_s_tdata[15];
            r0_a   <= i_s_tdata[15] ? (16'd0 - i_s_tdata) : i_s_tdata;
            r0_sat <= (i_s_tdata == 16'h8000);
            // stage 1
            r1_m   <= n_m_full[30:0];
            r1_neg <= r0_neg;
            r1_sat <= r0_sat;
            // stage 2
            r2_y    <= n_y;
            r2_side <= {n_k, r1_neg, r1_sat};
            // stage 3: |log2(m) - 30|
            r3_lmag <= n_lmag[31:0];
            r3_neg  <= w_lg_side[1];
            r3_sat  <= w_lg_side[0];
            // stage 4: |w| = |L| * ln 2, rounded
            r4_wmag <= 32'((n_wprod + 62'(64'd1 << 29)) >> 30);
            r4_neg  <= r3_neg;
            r4_sat  <= r3_sat;
            // stage 5: t1 and |t2|
            r5_t1  <= $signed({2'b00, C_T1}) - $signed({2'b00, r4_wmag[31:1]});
            r5_t2  <= 35'((64'(n_t2prod) + (64'd1 << (WFRAC - 1))) >> WFRAC);
            r5_neg <= r4_neg;
            r5_sat <= r4_sat;
            // stage 6: t1 squared
            r6_sq  <= {31'd0, n_t1abs} * {31'd0, n_t1abs};
            r6_t1  <= r5_t1;
            r6_t2  <= r5_t2;
            r6_neg <= r5_neg;
            r6_sat <= r5_sat;
            // stage 7: root operand d * 2^28
            r7_op   <= {n_d, 28'd0};
            r7_side <= {r6_t1, r6_neg, r6_sat};
            // stage 8: clamp s - t1 at zero
            r8_op   <= (!n_diff[33] && (n_diff != '0)) ? {3'd0, n_diff[32:0], 28'd0} : '0;
            r8_side <= w_sa_side[1:0];
            // output: round, clamp, apply sign
            if (w_sb_side[0]) begin
                r_out_val <= NEG_SAT;
            end else if (w_sb_side[1]) begin
                r_out_val <= 15'(15'd0 - {1'b0, n_mag_sat});
            end else begin
                r_out_val <= {1'b0, n_mag_sat};
            end
            r_out_sat <= w_sb_side[0];
        end
    end

    ierf_log2 #(
        .SIDE_W (7)
    ) u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_y     (r2_y),
        .i_side  (r2_side),
        .o_valid (w_lg_v),
        .o_frac  (w_lg_frac),
        .o_side  (w_lg_side)
    );

    ierf_isqrt #(
        .W      (64),
        .SIDE_W (35)
    ) u_sqrt_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r7_v),
        .i_op    (r7_op),
        .i_side  (r7_side),
        .o_valid (w_sa_v),
        .o_root  (w_sa_root),
        .o_side  (w_sa_side)
    );

    ierf_isqrt #(
        .W      (64),
        .SIDE_W (2)
    ) u_sqrt_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r8_v),
        .i_op    (r8_op),
        .i_side  (r8_side),
        .o_valid (w_sb_v),
        .o_root  (w_sb_root),
        .o_side  (w_sb_side)
    );

    assign o_m_tvalid = r_out_v;
    assign o_m_tdata  = {1'b0, r_out_val};
    assign o_m_tuser  = r_out_sat;

    // A result flagged as saturated always carries the most negative code.
    a_sat_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[14:0] == NEG_SAT))
        else $error("saturated result without the most negative code");

    // While the output is held, the pipeline must not move (checked on the stage 7 and 8 valid bits).
    a_hold_pipe : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> ($stable(r7_v) && $stable(r8_v)))
        else $error("pipeline advanced during a stall");

endmodule
